/* sv/two_wire_register_file_slave_macros.svh */
// Assertion macros for the two-wire register file slave.
// Used by the top level; no other dependencies.
`ifndef TWO_WIRE_REGISTER_FILE_SLAVE_MACROS_SVH
`define TWO_WIRE_REGISTER_FILE_SLAVE_MACROS_SVH
`ifndef SYNTHESIS
`define RFS_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("implication check failed");
`define RFS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("next-cycle check failed");
`else
`define RFS_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define RFS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

/* sv/rfs_pkg.sv */
// Shared types, constants and the register reset table for the two-wire
// register file slave. No dependencies.
package rfs_pkg;

	localparam int REGISTER_COUNT = 64;
	localparam int PTR_W          = 8;
	localparam int WORD_W         = 16;

	typedef enum logic [2:0] {
		MODE_START_RX = 3'd0,
		MODE_START_TX = 3'd1,
		MODE_STOP     = 3'd2,
		MODE_WRITE    = 3'd3,
		MODE_READ     = 3'd4
	} mode_t;

	// Request from the control path to the register bank for one beat.
	typedef struct packed {
		logic              wr_en;
		logic              clr;
		logic [PTR_W-1:0]  wr_addr;
		logic [WORD_W-1:0] wr_data;
		logic [PTR_W-1:0]  rd_addr;
	} bank_req_t;

	// Reset value of each register; registers not listed reset to zero.
	function automatic logic [WORD_W-1:0] default_word(input logic [PTR_W-1:0] idx);
		logic [WORD_W-1:0] w;
		begin
			case (idx)
				8'd0:    w = 16'h8990;
				8'd2:    w = 16'h6000;
				8'd4:    w = 16'h4050;
				8'd5:    w = 16'h4000;
				8'd6:    w = 16'h01c8;
				8'd8:    w = 16'h0040;
				8'd9:    w = 16'h0040;
				8'd10:   w = 16'h0004;
				8'd11:   w = 16'h00c0;
				8'd12:   w = 16'h00c0;
				8'd14:   w = 16'h0100;
				8'd15:   w = 16'h00c0;
				8'd16:   w = 16'h00c0;
				8'd19:   w = 16'h1000;
				8'd20:   w = 16'h1010;
				8'd21:   w = 16'h1010;
				8'd22:   w = 16'h8000;
				8'd23:   w = 16'h0800;
				8'd24:   w = 16'h008b;
				8'd25:   w = 16'h008b;
				8'd26:   w = 16'h008b;
				8'd27:   w = 16'h008b;
				8'd30:   w = 16'h0066;
				8'd31:   w = 16'h0022;
				8'd32:   w = 16'h0079;
				8'd33:   w = 16'h0079;
				8'd34:   w = 16'h0003;
				8'd35:   w = 16'h0003;
				8'd37:   w = 16'h0100;
				8'd51:   w = 16'h0180;
				8'd60:   w = 16'h0008;
				8'd61:   w = 16'h0031;
				8'd62:   w = 16'h0026;
				default: w = '0;
			endcase
			return w;
		end
	endfunction

endpackage

/* sv/rfs_bank.sv */
// Register bank: memory with per-entry valid bits and a registered read port.
// Depends on rfs_pkg.
module rfs_bank #(
	parameter int REGISTER_COUNT = rfs_pkg::REGISTER_COUNT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rfs_pkg::bank_req_t             req,
	output logic [rfs_pkg::WORD_W-1:0]     word
);

	localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

	logic [rfs_pkg::WORD_W-1:0] mem [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0]  vld_q;
	logic [rfs_pkg::WORD_W-1:0] rd_data_q;
	logic                       rd_vld_q;
	logic [rfs_pkg::PTR_W-1:0]  rd_addr_q;
	logic [AW-1:0]              wr_idx;
	logic [AW-1:0]              rd_idx;
	logic                       fwd;
	logic                       in_range;

	assign wr_idx = req.wr_addr[AW-1:0];
	assign rd_idx = req.rd_addr[AW-1:0];
	assign fwd    = req.wr_en && (req.wr_addr == req.rd_addr);

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wr_idx] <= req.wr_data;
		end
		rd_data_q <= fwd ? req.wr_data : mem[rd_idx];
	end

	// A cleared entry reads back its table value until it is written again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			rd_vld_q  <= !req.clr && (fwd || vld_q[rd_idx]);
			rd_addr_q <= req.rd_addr;
		end
	end

	assign in_range = {1'b0, rd_addr_q} < (rfs_pkg::PTR_W+1)'(REGISTER_COUNT);

	always_comb begin
		if (!in_range) begin
			word = '0;
		end else if (rd_vld_q) begin
			word = rd_data_q;
		end else begin
			word = rfs_pkg::default_word(rd_addr_q);
		end
	end

endmodule

/* sv/rfs_ctrl.sv */
// Control path: input register, pointer and byte-phase state, result register.
// Depends on rfs_pkg.
module rfs_ctrl #(
	parameter int REGISTER_COUNT = rfs_pkg::REGISTER_COUNT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [2:0]                 mode,
	input  logic [7:0]                 data_byte,
	input  logic [rfs_pkg::WORD_W-1:0] word,
	output rfs_pkg::bank_req_t         req,
	output logic                       strobe,
	output logic [7:0]                 read_byte
);

	logic       valid_s1;
	logic [2:0] mode_s1;
	logic [7:0] byte_s1;

	logic [rfs_pkg::PTR_W-1:0] ptr_q, ptr_d;
	logic [7:0]                held_q, held_d;
	logic                      await_q, await_d;
	logic                      low_q, low_d;
	logic [7:0]                rd_byte;
	logic                      strobe_q;
	logic [7:0]                read_byte_q;
	logic                      ptr_in_range;

	assign ptr_in_range = {1'b0, ptr_q} < (rfs_pkg::PTR_W+1)'(REGISTER_COUNT);

	always_comb begin
		ptr_d       = ptr_q;
		held_d      = held_q;
		await_d     = await_q;
		low_d       = low_q;
		rd_byte     = '0;
		req.wr_en   = 1'b0;
		req.clr     = 1'b0;
		req.wr_addr = ptr_q;
		req.wr_data = {held_q, byte_s1};
		if (valid_s1) begin
			case (mode_s1)
				rfs_pkg::MODE_START_RX: begin
					low_d = 1'b0;
				end
				rfs_pkg::MODE_START_TX: begin
					await_d = 1'b1;
					low_d   = 1'b0;
				end
				rfs_pkg::MODE_STOP: begin
					await_d = 1'b0;
					low_d   = 1'b0;
				end
				rfs_pkg::MODE_WRITE: begin
					if (await_q) begin
						ptr_d   = byte_s1;
						await_d = 1'b0;
					end else if (!low_q) begin
						held_d = byte_s1;
						low_d  = 1'b1;
					end else begin
						ptr_d = ptr_q + rfs_pkg::PTR_W'(1);
						low_d = 1'b0;
						// A write to register zero restores the whole bank.
						if (ptr_q == '0) begin
							req.clr = 1'b1;
						end else if (ptr_in_range) begin
							req.wr_en = 1'b1;
						end
					end
				end
				rfs_pkg::MODE_READ: begin
					if (!low_q) begin
						rd_byte = word[15:8];
						low_d   = 1'b1;
					end else begin
						rd_byte = word[7:0];
						low_d   = 1'b0;
						ptr_d   = ptr_q + rfs_pkg::PTR_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
		req.rd_addr = ptr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			ptr_q       <= '0;
			held_q      <= '0;
			await_q     <= 1'b0;
			low_q       <= 1'b0;
			strobe_q    <= 1'b0;
			read_byte_q <= '0;
		end else begin
			valid_s1    <= start;
			ptr_q       <= ptr_d;
			held_q      <= held_d;
			await_q     <= await_d;
			low_q       <= low_d;
			strobe_q    <= valid_s1;
			read_byte_q <= rd_byte;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		byte_s1 <= data_byte;
	end

	assign strobe    = strobe_q;
	assign read_byte = read_byte_q;

endmodule

/* sv/two_wire_register_file_slave.sv */
// Two-wire bus slave fronting a bank of sixteen-bit registers.
// Timing: a beat passes the input register and then the result register that drives its strobe.
// Throughput: one beat every cycle; busy never rises, and the bank read port
// is registered ahead of use on the next pointer value.
// Reset: arst_n clears pointer, flags and valid bits at once; every register
// then reads its table value, with no clearing pass.
`include "two_wire_register_file_slave_macros.svh"
module two_wire_register_file_slave #(
	parameter int REGISTER_COUNT = rfs_pkg::REGISTER_COUNT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] mode,
	input  logic [7:0] data_byte,
	output logic       strobe,
	output logic [7:0] read_byte
);

	rfs_pkg::bank_req_t         req;
	logic [rfs_pkg::WORD_W-1:0] word;

	assign busy = 1'b0;

	rfs_ctrl #(
		.REGISTER_COUNT(REGISTER_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.data_byte (data_byte),
		.word      (word),
		.req       (req),
		.strobe    (strobe),
		.read_byte (read_byte)
	);

	rfs_bank #(
		.REGISTER_COUNT(REGISTER_COUNT)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.word   (word)
	);

	`RFS_ASSERT_IMPLIES(a_strobe_from_beat, clk, arst_n, strobe, $past(start, 2))
	`RFS_ASSERT_IMPLIES(a_idle_zero, clk, arst_n, !strobe, read_byte == '0)
	`RFS_ASSERT_IMPLIES(a_nonread_zero, clk, arst_n, strobe && ($past(mode, 2) != rfs_pkg::MODE_READ), read_byte == '0)
	`RFS_ASSERT_NEXT(a_clr_no_write, clk, arst_n, req.clr, !$past(req.wr_en))

endmodule
